// ----- hw/rtl/pid_poi_pkg.sv -----
package pid_poi_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int GAIN_W     = 24;
    localparam int LIMIT_W    = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE           = 3'd0,
        REG_GAIN_P         = 3'd1,
        REG_GAIN_I         = 3'd2,
        REG_GAIN_D         = 3'd3,
        REG_INTEGRAL_LIMIT = 3'd4,
        REG_OUTPUT_LIMIT   = 3'd5
    } t_cfg_reg;

    typedef enum logic {
        MODE_POSITIONAL  = 1'b0,
        MODE_INCREMENTAL = 1'b1
    } t_mode;

endpackage

// ----- hw/rtl/pid_poi_mulq.sv -----
// Fixed-point gain multiply: floor((gain * x) / 2^FRAC_BITS), saturated to DATA_WIDTH.
module pid_poi_mulq #(
    parameter int DATA_WIDTH = pid_poi_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pid_poi_pkg::FRAC_BITS_DEF,
    parameter int X_W        = DATA_WIDTH + 2
) (
    input  logic signed [pid_poi_pkg::GAIN_W-1:0] i_gain,
    input  logic signed [X_W-1:0]                 i_x,
    output logic signed [DATA_WIDTH-1:0]          o_y
);

    localparam int PROD_W = pid_poi_pkg::GAIN_W + X_W;
    localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MAX_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] shifted;
    logic [PROD_W-DATA_WIDTH:0] top;

    always_comb begin
        prod    = PROD_W'(i_gain) * PROD_W'(i_x);
        shifted = prod >>> FRAC_BITS;
        top     = shifted[PROD_W-1:DATA_WIDTH-1];
        if ((&top) || !(|top)) begin
            o_y = shifted[DATA_WIDTH-1:0];
        end else if (shifted[PROD_W-1]) begin
            o_y = MAX_NEG;
        end else begin
            o_y = MAX_POS;
        end
    end

endmodule

// ----- hw/rtl/pid_position_or_incremental_core.sv -----
// PID controller, positional or incremental, signed fixed point (Q16.16 by default).
// Input channel: i_in_valid / o_in_stall with i_setpoint and i_measured; a request is
// taken at a clock edge with valid high and stall low. Output channel: o_out_valid /
// i_out_stall with o_drive and o_output_clamped, one result per request, in order.
// Configuration: i_cfg_valid / o_cfg_ready with register index and data; ready is
// always high, unknown indexes are ignored. Write registers only while idle.
// Pipeline: error stage, multiplier stage (three gain multiplies), sum/clamp stage
// into the output register; a request goes through r_e_a, r_tp/r_ti/r_td and r_drive.
// Throughput is one request per cycle while the receiver does not stall; the integral
// accumulator and previous output close their loop inside the sum/clamp stage.
// When the receiver stalls, the result holds in the output register and the stages
// behind it keep filling; o_in_stall rises once the error stage cannot move on.
// Reset (i_rst_n low, synchronous) empties the pipeline and clears the mode, gains,
// limits, stored errors, integral accumulator and previous output to zero.
module pid_position_or_incremental_core #(
    parameter int DATA_WIDTH = pid_poi_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pid_poi_pkg::FRAC_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [DATA_WIDTH-1:0]            i_setpoint,
    input  logic signed [DATA_WIDTH-1:0]            i_measured,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [DATA_WIDTH-1:0]            o_drive,
    output logic                                    o_output_clamped,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [pid_poi_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pid_poi_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int GW    = pid_poi_pkg::GAIN_W;
    localparam int XW    = DATA_WIDTH + 2;
    localparam int LIM_W = pid_poi_pkg::LIMIT_W + FRAC_BITS;
    localparam int ACC_W = ((DATA_WIDTH > LIM_W) ? DATA_WIDTH : LIM_W) + 1;
    localparam int SUM_W = ACC_W + 2;
    localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MAX_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // configuration
    pid_poi_pkg::t_mode                  r_mode;
    logic signed [GW-1:0]                r_gain_p;
    logic signed [GW-1:0]                r_gain_i;
    logic signed [GW-1:0]                r_gain_d;
    logic [pid_poi_pkg::LIMIT_W-1:0]     r_int_limit;
    logic [pid_poi_pkg::LIMIT_W-1:0]     r_out_limit;

    // pipeline control
    logic r_va, r_vb, r_vc;
    logic adv_b, adv_c, in_acc;

    // controller state
    logic signed [DATA_WIDTH-1:0] r_e1, r_e2;
    logic signed [ACC_W-1:0]      r_acc;
    logic signed [DATA_WIDTH-1:0] r_out_prev;

    // stage payloads
    logic signed [DATA_WIDTH-1:0] r_e_a;
    logic signed [DATA_WIDTH-1:0] r_tp, r_ti, r_td;
    logic signed [DATA_WIDTH-1:0] r_drive;
    logic                         r_clamped;

    logic signed [DATA_WIDTH:0]   diff_in;
    logic signed [DATA_WIDTH-1:0] n_e;
    logic signed [XW-1:0]         e_x, e1_x, e2_x;
    logic signed [XW-1:0]         x_p, x_d;
    logic signed [DATA_WIDTH-1:0] tp, ti, td;

    logic signed [SUM_W-1:0] lim_i, lim_o;
    logic signed [SUM_W-1:0] int_raw, int_clamp;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [SUM_W-1:0] out_raw, out_clamp;
    logic [SUM_W-DATA_WIDTH:0] out_top;
    logic signed [DATA_WIDTH-1:0] n_drive;
    logic                         n_clamped;

    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_vc;
    assign o_drive          = r_drive;
    assign o_output_clamped = r_clamped;

    assign adv_c      = r_vb && (!r_vc || !i_out_stall);
    assign adv_b      = r_va && (!r_vb || adv_c);
    assign o_in_stall = r_va && !adv_b;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= pid_poi_pkg::MODE_POSITIONAL;
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_int_limit <= '0;
            r_out_limit <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (pid_poi_pkg::t_cfg_reg'(i_cfg_index))
                pid_poi_pkg::REG_MODE:           r_mode <= pid_poi_pkg::t_mode'(i_cfg_data[0]);
                pid_poi_pkg::REG_GAIN_P:         r_gain_p <= i_cfg_data;
                pid_poi_pkg::REG_GAIN_I:         r_gain_i <= i_cfg_data;
                pid_poi_pkg::REG_GAIN_D:         r_gain_d <= i_cfg_data;
                pid_poi_pkg::REG_INTEGRAL_LIMIT: begin
                    r_int_limit <= i_cfg_data[pid_poi_pkg::LIMIT_W-1:0];
                end
                pid_poi_pkg::REG_OUTPUT_LIMIT:   begin
                    r_out_limit <= i_cfg_data[pid_poi_pkg::LIMIT_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // error stage
    always_comb begin
        diff_in = (DATA_WIDTH+1)'(i_setpoint) - (DATA_WIDTH+1)'(i_measured);
        if (diff_in[DATA_WIDTH] == diff_in[DATA_WIDTH-1]) begin
            n_e = diff_in[DATA_WIDTH-1:0];
        end else if (diff_in[DATA_WIDTH]) begin
            n_e = MAX_NEG;
        end else begin
            n_e = MAX_POS;
        end
    end

    // multiplier stage operands
    always_comb begin
        e_x  = XW'(r_e_a);
        e1_x = XW'(r_e1);
        e2_x = XW'(r_e2);
        if (r_mode == pid_poi_pkg::MODE_POSITIONAL) begin
            x_p = e_x;
            x_d = e_x - e1_x;
        end else begin
            x_p = e_x - e1_x;
            x_d = e_x - (e1_x <<< 1) + e2_x;
        end
    end

    pid_poi_mulq #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .X_W(XW)) u_mul_p (
        .i_gain (r_gain_p),
        .i_x    (x_p),
        .o_y    (tp)
    );

    pid_poi_mulq #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .X_W(XW)) u_mul_i (
        .i_gain (r_gain_i),
        .i_x    (e_x),
        .o_y    (ti)
    );

    pid_poi_mulq #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .X_W(XW)) u_mul_d (
        .i_gain (r_gain_d),
        .i_x    (x_d),
        .o_y    (td)
    );

    // sum and clamp stage
    always_comb begin
        lim_i = SUM_W'({r_int_limit, {FRAC_BITS{1'b0}}});
        lim_o = SUM_W'({r_out_limit, {FRAC_BITS{1'b0}}});

        if (r_mode == pid_poi_pkg::MODE_POSITIONAL) begin
            int_raw = SUM_W'(r_acc) + SUM_W'(r_ti);
        end else begin
            int_raw = SUM_W'(r_ti);
        end
        if (int_raw > lim_i) begin
            int_clamp = lim_i;
        end else if (int_raw < -lim_i) begin
            int_clamp = -lim_i;
        end else begin
            int_clamp = int_raw;
        end
        n_acc = int_clamp[ACC_W-1:0];

        out_raw = SUM_W'(r_tp) + int_clamp + SUM_W'(r_td);
        if (r_mode == pid_poi_pkg::MODE_INCREMENTAL) begin
            out_raw = out_raw + SUM_W'(r_out_prev);
        end
        n_clamped = 1'b0;
        if (out_raw > lim_o) begin
            out_clamp = lim_o;
            n_clamped = 1'b1;
        end else if (out_raw < -lim_o) begin
            out_clamp = -lim_o;
            n_clamped = 1'b1;
        end else begin
            out_clamp = out_raw;
        end

        out_top = out_clamp[SUM_W-1:DATA_WIDTH-1];
        if ((&out_top) || !(|out_top)) begin
            n_drive = out_clamp[DATA_WIDTH-1:0];
        end else if (out_clamp[SUM_W-1]) begin
            n_drive = MAX_NEG;
        end else begin
            n_drive = MAX_POS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va       <= 1'b0;
            r_vb       <= 1'b0;
            r_vc       <= 1'b0;
            r_e1       <= '0;
            r_e2       <= '0;
            r_acc      <= '0;
            r_out_prev <= '0;
        end else begin
            if (in_acc) begin
                r_va <= 1'b1;
            end else if (adv_b) begin
                r_va <= 1'b0;
            end

            if (adv_b) begin
                r_vb <= 1'b1;
                r_e1 <= r_e_a;
                r_e2 <= r_e1;
            end else if (adv_c) begin
                r_vb <= 1'b0;
            end

            if (adv_c) begin
                r_vc  <= 1'b1;
                r_acc <= n_acc;
                if (r_mode == pid_poi_pkg::MODE_INCREMENTAL) begin
                    r_out_prev <= n_drive;
                end
            end else if (!i_out_stall) begin
                r_vc <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_e_a <= n_e;
        end
        if (adv_b) begin
            r_tp <= tp;
            r_ti <= ti;
            r_td <= td;
        end
        if (adv_c) begin
            r_drive   <= n_drive;
            r_clamped <= n_clamped;
        end
    end

endmodule

// ----- hw/rtl/pid_poi_check.sv -----
module pid_poi_check #(
    parameter int DATA_WIDTH = pid_poi_pkg::DATA_WIDTH_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [DATA_WIDTH-1:0] o_drive,
    input logic                  o_output_clamped
);

    // pipeline is empty the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // an accepted request reaches the output when the receiver keeps taking
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 !i_out_stall ##1 !i_out_stall |=> o_out_valid)
        else $error("result missing three cycles after request");

    // a stalled result is held
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_drive) && $stable(o_output_clamped))
        else $error("stalled result changed");

endmodule

bind pid_position_or_incremental_core pid_poi_check #(.DATA_WIDTH(DATA_WIDTH)) u_check (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_drive          (o_drive),
    .o_output_clamped (o_output_clamped)
);

// ----- tb/pid_drive_monitor.sv -----
module pid_drive_monitor
    import pid_poi_pkg::*;
#(
    parameter int DW = DATA_WIDTH_DEF,
    parameter int FB = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic signed [DW-1:0]  i_setpoint,
    input  logic signed [DW-1:0]  i_measured,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic signed [DW-1:0]  i_drive,
    input  logic                  i_output_clamped,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_outstanding,
    output int                    o_results
);

    typedef struct packed {
        logic signed [DW-1:0] drive;
        logic                 clamped;
    } t_drive;

    t_mode   ctl_mode;
    longint  kp, ki, kd, integ_lim, drive_lim;
    longint  err_last, err_before, integ_acc, drive_last;
    t_drive  drive_q[$];
    t_drive  want;
    int      bad_count = 0;
    int      seen = 0;

    function automatic longint sat_word(input longint v);
        longint hi, lo;
        hi = (longint'(1) <<< (DW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // product floored by the fraction bits, then saturated to the word
    function automatic longint gain_mul(input longint g, input longint x);
        return sat_word((g * x) >>> FB);
    endfunction

    function automatic longint clamp_sym(input longint v, input longint lim, output logic hit);
        hit = 1'b1;
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        hit = 1'b0;
        return v;
    endfunction

    function automatic t_drive next_drive(input longint sp, input longint ms);
        longint e, p, i, d, y;
        logic   hit_i, hit_o;
        t_drive r;
        e = sat_word(sp - ms);
        if (ctl_mode == MODE_POSITIONAL) begin
            p = gain_mul(kp, e);
            i = clamp_sym(integ_acc + gain_mul(ki, e), integ_lim, hit_i);
            d = gain_mul(kd, e - err_last);
            y = clamp_sym(p + i + d, drive_lim, hit_o);
            y = sat_word(y);
        end else begin
            p = gain_mul(kp, e - err_last);
            i = clamp_sym(gain_mul(ki, e), integ_lim, hit_i);
            d = gain_mul(kd, e - 2 * err_last + err_before);
            y = clamp_sym(drive_last + p + i + d, drive_lim, hit_o);
            y = sat_word(y);
            drive_last = y;
        end
        integ_acc  = i;
        err_before = err_last;
        err_last   = e;
        r.drive    = y[DW-1:0];
        r.clamped  = hit_o;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ctl_mode   = MODE_POSITIONAL;
            kp         = 0;
            ki         = 0;
            kd         = 0;
            integ_lim  = 0;
            drive_lim  = 0;
            err_last   = 0;
            err_before = 0;
            integ_acc  = 0;
            drive_last = 0;
            drive_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_MODE:           ctl_mode  = t_mode'(i_cfg_data[0]);
                    REG_GAIN_P:         kp        = longint'(signed'(i_cfg_data[GAIN_W-1:0]));
                    REG_GAIN_I:         ki        = longint'(signed'(i_cfg_data[GAIN_W-1:0]));
                    REG_GAIN_D:         kd        = longint'(signed'(i_cfg_data[GAIN_W-1:0]));
                    REG_INTEGRAL_LIMIT: integ_lim = longint'(i_cfg_data[LIMIT_W-1:0]) <<< FB;
                    REG_OUTPUT_LIMIT:   drive_lim = longint'(i_cfg_data[LIMIT_W-1:0]) <<< FB;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                seen++;
                if (drive_q.size() == 0) begin
                    if (bad_count < 10)
                        $display("result %0d: drive %0d clamp %0b with no request outstanding",
                                 seen, i_drive, i_output_clamped);
                    bad_count++;
                end else begin
                    want = drive_q.pop_front();
                    if (want.drive !== i_drive || want.clamped !== i_output_clamped) begin
                        if (bad_count < 10)
                            $display("result %0d: drive exp %0d got %0d, clamp exp %0b got %0b",
                                     seen, $signed(want.drive), i_drive, want.clamped,
                                     i_output_clamped);
                        bad_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                drive_q.push_back(next_drive(longint'(i_setpoint), longint'(i_measured)));
        end
        o_mismatches  <= bad_count;
        o_outstanding <= drive_q.size();
        o_results     <= seen;
    end

endmodule

// ----- tb/pid_position_or_incremental_core_tb.sv -----
module pid_position_or_incremental_core_tb;
    import pid_poi_pkg::*;

    localparam int DW         = DATA_WIDTH_DEF;
    localparam int ONE        = 1 << FRAC_BITS_DEF;
    localparam int IDLE_LIMIT = 2000;

    localparam logic signed [DW-1:0]     W_MAX    = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0]     W_MIN    = {1'b1, {(DW-1){1'b0}}};
    localparam logic [GAIN_W-1:0]        GAIN_ONE = 24'h010000;
    localparam logic [GAIN_W-1:0]        GAIN_MAX = 24'h7FFFFF;
    localparam logic [GAIN_W-1:0]        GAIN_MIN = 24'h800000;
    localparam logic [LIMIT_W-1:0]       LIM_MAX  = 15'h7FFF;
    localparam logic [CFG_IDX_W-1:0]     REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0]     REG_SPARE_7 = 3'd7;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic signed [DW-1:0]   i_setpoint;
    logic signed [DW-1:0]   i_measured;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic signed [DW-1:0]   o_drive;
    logic                   o_output_clamped;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int   mismatches, pending, results;
    int   n_req = 0;
    int   n_cfg = 0;
    int   n_setups = 0;
    int   quiet_cycles = 0;
    int   hold_left = 0;
    int   target = 0;
    logic calm = 1'b0;

    always #4 i_clk = ~i_clk;

    pid_position_or_incremental_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_setpoint       (i_setpoint),
        .i_measured       (i_measured),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_drive          (o_drive),
        .o_output_clamped (o_output_clamped),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    pid_drive_monitor u_monitor (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_setpoint       (i_setpoint),
        .i_measured       (i_measured),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_drive          (o_drive),
        .i_output_clamped (o_output_clamped),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_mismatches     (mismatches),
        .o_outstanding    (pending),
        .o_results        (results)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return GAIN_MAX;
            1:       return GAIN_MIN;
            2:       return '0;
            3, 4:    return GAIN_W'($urandom);
            default: return GAIN_W'(int'($urandom_range(0, 32'h40000)) - 32'sh20000);
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] pick_limit();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return '0;
            1:       return LIM_MAX;
            2:       return LIMIT_W'($urandom_range(0, 32767));
            default: return LIMIT_W'($urandom_range(1, 600));
        endcase
    endfunction

    function automatic logic signed [DW-1:0] corner_word();
        case ($urandom_range(0, 4))
            0:       return W_MAX;
            1:       return W_MIN;
            2:       return '0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            hold_left = 0;
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0) hold_left = gap_len();
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("no handshake for %0d cycles", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send(input logic signed [DW-1:0] sp, input logic signed [DW-1:0] ms);
        int gap;
        gap = calm ? 0 : gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_setpoint <= sp;
        i_measured <= ms;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_req++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        n_cfg++;
    endtask

    task automatic configure(input t_mode m, input logic [GAIN_W-1:0] gp,
                             input logic [GAIN_W-1:0] gi, input logic [GAIN_W-1:0] gd,
                             input logic [LIMIT_W-1:0] il, input logic [LIMIT_W-1:0] ol,
                             input bit spare);
        drain();
        write_reg(REG_MODE, CFG_DATA_W'(m));
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_I, gi);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_INTEGRAL_LIMIT, CFG_DATA_W'(il));
        write_reg(REG_OUTPUT_LIMIT, CFG_DATA_W'(ol));
        // unused indexes must leave every register alone
        if (spare) begin
            write_reg(REG_SPARE_6, CFG_DATA_W'($urandom));
            write_reg(REG_SPARE_7, CFG_DATA_W'($urandom));
        end
        i_cfg_valid <= 1'b0;
        n_setups++;
    endtask

    task automatic next_sample(output logic signed [DW-1:0] sp, output logic signed [DW-1:0] ms);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            // held setpoint with measurement noise around it
            if ($urandom_range(0, 15) == 0)
                target = int'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
            sp = target;
            ms = target + int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        end else if (r < 85) begin
            sp = $urandom;
            ms = $urandom;
        end else begin
            sp = corner_word();
            ms = corner_word();
        end
    endtask

    initial begin
        logic signed [DW-1:0] sp, ms;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_setpoint  <= '0;
        i_measured  <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: all gains and limits zero
        send(3 * ONE, ONE);
        send(W_MAX, W_MIN);

        // output exactly at its limit, then one lsb past it
        configure(MODE_POSITIONAL, GAIN_ONE, '0, '0, '0, 15'd100, 1'b0);
        send(100 * ONE, 0);
        send(100 * ONE + 1, 0);
        send(0, 100 * ONE);
        send(0, 100 * ONE + 1);
        send(0, 0);

        configure(MODE_INCREMENTAL, GAIN_MAX, GAIN_MIN, GAIN_MAX, LIM_MAX, LIM_MAX, 1'b1);
        send(W_MAX, W_MIN);
        send(W_MIN, W_MAX);
        send(W_MAX, W_MAX);
        send(0, W_MIN);
        send(W_MIN, 0);

        // zero limits force term and output to zero
        configure(MODE_POSITIONAL, 24'h008000, 24'h004000, 24'h020000, '0, '0, 1'b0);
        send(5 * ONE, ONE);
        send(W_MIN, W_MAX);

        // integral winds up into its clamp
        configure(MODE_POSITIONAL, 24'h008000, GAIN_ONE, 24'h020000, 15'd20, 15'd200, 1'b0);
        repeat (5) send(8 * ONE, 0);

        configure(MODE_INCREMENTAL, GAIN_ONE, GAIN_ONE, GAIN_ONE, 15'd10, 15'd50, 1'b0);
        repeat (3) send(20 * ONE, 0);

        for (int ph = 0; ph < 8; ph++) begin
            calm <= (ph % 3 == 2);
            configure((ph % 2 == 0) ? MODE_POSITIONAL : MODE_INCREMENTAL, pick_gain(),
                      pick_gain(), pick_gain(), pick_limit(), pick_limit(), ph % 4 == 1);
            repeat (110) begin
                next_sample(sp, ms);
                send(sp, ms);
            end
        end

        drain();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d samples over %0d settings in both modes (%0d register writes),",
                 n_req, n_setups, n_cfg);
        $display("covering saturating errors, limit edges and zero limits; %0d results checked.",
                 results);
        if (mismatches == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/pid_poi_pkg.sv
hw/rtl/pid_poi_mulq.sv
hw/rtl/pid_position_or_incremental_core.sv
hw/rtl/pid_poi_check.sv
tb/pid_drive_monitor.sv
tb/pid_position_or_incremental_core_tb.sv
